@@ rtl/cfam_pkg.sv @@
// Shared types and constants for the circular feathered alpha mask.
package cfam_pkg;

    // Field and register widths.
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int RADIUS_W   = 20;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Distance datapath widths.
    localparam int SQ_W       = 24;
    localparam int D2_W       = 25;
    localparam int RAD_W      = 42;
    localparam int ROOT_W     = 21;
    localparam int REM_W      = 23;
    localparam int SQRT_STEPS = 21;
    localparam int OFF_W      = 22;
    localparam int BAND_W     = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    // Feather band: five pixels in Q8, and the alpha ramp.
    localparam logic [OFF_W-1:0] FEATHER_Q8  = 22'd1280;
    localparam logic [15:0]      FULL_Q8     = 16'd65280;
    localparam logic [5:0]       ALPHA_SLOPE = 6'd51;
    localparam logic [PIX_W-1:0] PIX_WHITE   = 8'hFF;
    localparam logic [PIX_W-1:0] ALPHA_CLEAR = 8'h00;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_pixel;

    // One item in flight through the square root pipeline.
    typedef struct packed {
        logic [D2_W-1:0]   d2;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        t_pixel            pix;
    } t_sq_item;

    typedef enum logic [1:0] {
        ZONE_IN,
        ZONE_BAND,
        ZONE_OUT
    } t_zone;

endpackage

@@ rtl/cfam_front.sv @@
// Front stages: centre offsets, squares and the squared distance.
module cfam_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cfam_pkg::COORD_W-1:0]  i_col,
    input  logic [cfam_pkg::COORD_W-1:0]  i_row,
    input  cfam_pkg::t_pixel              i_pix,
    input  logic [cfam_pkg::COORD_W-1:0]  i_half_w,
    input  logic [cfam_pkg::COORD_W-1:0]  i_half_h,
    output logic                          o_valid,
    input  logic                          i_ready,
    output cfam_pkg::t_sq_item            o_item
);
    import cfam_pkg::*;

    logic                    r_va;
    logic                    r_vb;
    logic                    r_vc;
    logic                    rdy_a;
    logic                    rdy_b;
    logic                    rdy_c;
    logic signed [DIM_W-1:0] r_dx;
    logic signed [DIM_W-1:0] r_dy;
    t_pixel                  r_pix_a;
    logic [SQ_W-1:0]         r_sqx;
    logic [SQ_W-1:0]         r_sqy;
    t_pixel                  r_pix_b;
    t_sq_item                r_item;
    logic signed [DIM_W-1:0] n_dx;
    logic signed [DIM_W-1:0] n_dy;
    logic signed [2*DIM_W-1:0] prod_x;
    logic signed [2*DIM_W-1:0] prod_y;
    t_sq_item                n_item;

    // A stage takes a new transfer when it is empty or its successor moves.
    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
    end

    // Stage A: signed offsets from the image centre.
    assign n_dx = $signed({1'b0, i_col}) - $signed({1'b0, i_half_w});
    assign n_dy = $signed({1'b0, i_row}) - $signed({1'b0, i_half_h});

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_pix_a <= i_pix;
        end
    end

    // Stage B: squares; each magnitude is below 4096, so 24 bits hold them.
    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_sqx   <= prod_x[SQ_W-1:0];
            r_sqy   <= prod_y[SQ_W-1:0];
            r_pix_b <= r_pix_a;
        end
    end

    // Stage C: squared distance, square root state cleared.
    always_comb begin
        n_item      = '0;
        n_item.d2   = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_item.pix  = r_pix_b;
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_vb) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/cfam_sqrt_step.sv @@
// One pipelined digit step of the restoring integer square root.
module cfam_sqrt_step #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cfam_pkg::t_sq_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output cfam_pkg::t_sq_item o_item
);
    import cfam_pkg::*;

    logic [RAD_W-1:0]   rad;
    logic [1:0]         pair;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    t_sq_item           n_item;
    logic               r_valid;
    t_sq_item           r_item;

    // The radicand is the squared distance scaled by 2^16.
    assign rad  = {1'b0, i_item.d2, 16'b0};
    assign pair = rad[RAD_W-1-2*STEP -: 2];

    // Bring in the next two radicand bits and try the next root bit.
    assign rem_sh = {i_item.rem, pair};
    assign trial  = {{(REM_W-ROOT_W){1'b0}}, i_item.root, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb begin
        n_item = i_item;
        if (rem_sh >= trial) begin
            n_item.rem  = diff[REM_W-1:0];
            n_item.root = {i_item.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_item.rem  = rem_sh[REM_W-1:0];
            n_item.root = {i_item.root[ROOT_W-2:0], 1'b0};
        end
    end

    // Pipeline register with its valid bit.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

`ifndef NO_ASSERTIONS
    // The partial remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_item.rem <= {{(REM_W-ROOT_W-1){1'b0}}, r_item.root, 1'b0})
        else $error("square root remainder out of range");
`endif

endmodule

@@ rtl/cfam_shade.sv @@
// Back stages: offset from the radius, zone decision and alpha ramp.
module cfam_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cfam_pkg::t_sq_item            i_item,
    input  logic [cfam_pkg::RADIUS_W-1:0] i_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output cfam_pkg::t_pixel              o_pix
);
    import cfam_pkg::*;

    logic              r_v1;
    logic              r_v2;
    logic              rdy1;
    logic              rdy2;
    t_zone             r_zone;
    logic [BAND_W-1:0] r_off;
    t_pixel            r_pix1;
    t_pixel            r_pix_out;
    logic [OFF_W-1:0]  off;
    t_zone             n_zone;
    logic [16:0]       slope_prod;
    logic [15:0]       ramp;
    t_pixel            n_pix;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_pix   = r_pix_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // Stage 1: signed offset of the distance past the radius.
    assign off = {1'b0, i_item.root} - {2'b0, i_radius};

    always_comb begin
        if (off[OFF_W-1]) begin
            n_zone = ZONE_IN;
        end else if (off > FEATHER_Q8) begin
            n_zone = ZONE_OUT;
        end else begin
            n_zone = ZONE_BAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_zone <= n_zone;
            r_off  <= off[BAND_W-1:0];
            r_pix1 <= i_item.pix;
        end
    end

    // Stage 2: alpha is floor((255*256 - 51*off) / 256) inside the band.
    assign slope_prod = {6'b0, r_off} * {11'b0, ALPHA_SLOPE};
    assign ramp       = FULL_Q8 - slope_prod[15:0];

    always_comb begin
        n_pix = r_pix1;
        case (r_zone)
            ZONE_IN: begin
                n_pix = r_pix1;
            end
            ZONE_BAND: begin
                n_pix.alpha = ramp[15:8];
            end
            ZONE_OUT: begin
                n_pix.red   = PIX_WHITE;
                n_pix.green = PIX_WHITE;
                n_pix.blue  = PIX_WHITE;
                n_pix.alpha = ALPHA_CLEAR;
            end
            default: begin
                n_pix = r_pix1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_pix_out <= n_pix;
        end
    end

`ifndef NO_ASSERTIONS
    // A pixel classed in the band has an offset no larger than five pixels.
    a_band_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && (r_zone == ZONE_BAND) |-> {{(OFF_W-BAND_W){1'b0}}, r_off} <= FEATHER_Q8)
        else $error("band offset beyond feather limit");
`endif

endmodule

@@ rtl/circular_feathered_alpha_mask.sv @@
// Top level of the circular feathered alpha mask.
//
//  channel   direction  handshake                 payload
//  pixel in  input      i_valid / o_ready         i_col, i_row, i_*_in
//  pixel out output     o_valid / i_ready         o_*_out
//  config    input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per clock is accepted while the output is not stalled; each pixel
// passes 3 front stages, 21 square root stages and 2 shading stages.
// Every stage has its own valid bit and takes a transfer when it is empty or
// its successor moves, so a stalled output holds while bubbles fill up.
// Reset is synchronous; it empties the pipeline and restores the registers.
// The configuration port is always ready.
module circular_feathered_alpha_mask #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cfam_pkg::COORD_W-1:0]    i_col,
    input  logic [cfam_pkg::COORD_W-1:0]    i_row,
    input  logic [cfam_pkg::PIX_W-1:0]      i_red_in,
    input  logic [cfam_pkg::PIX_W-1:0]      i_green_in,
    input  logic [cfam_pkg::PIX_W-1:0]      i_blue_in,
    input  logic [cfam_pkg::PIX_W-1:0]      i_alpha_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cfam_pkg::PIX_W-1:0]      o_red_out,
    output logic [cfam_pkg::PIX_W-1:0]      o_green_out,
    output logic [cfam_pkg::PIX_W-1:0]      o_blue_out,
    output logic [cfam_pkg::PIX_W-1:0]      o_alpha_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cfam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfam_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cfam_pkg::*;

    localparam logic [31:0] MAX_DIM_U     = 32'(MAX_DIM);
    localparam logic [31:0] RST_RAD_FULL  = (MAX_DIM_U / 32'd2) * 32'd256;
    localparam logic [DIM_W-1:0]    RST_DIM    = MAX_DIM_U[DIM_W-1:0];
    localparam logic [RADIUS_W-1:0] RST_RADIUS = RST_RAD_FULL[RADIUS_W-1:0];

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [RADIUS_W-1:0] r_radius;
    t_pixel              in_pix;
    t_pixel              out_pix;
    t_sq_item            sq_item  [SQRT_STEPS+1];
    logic                sq_valid [SQRT_STEPS+1];
    logic                sq_ready [SQRT_STEPS+1];

    // Configuration registers; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_DIM;
            r_height <= RST_DIM;
            r_radius <= RST_RADIUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                REG_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in,
                      alpha: i_alpha_in};

    // Squared distance from the centre.
    cfam_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_col    (i_col),
        .i_row    (i_row),
        .i_pix    (in_pix),
        .i_half_w (r_width[DIM_W-1:1]),
        .i_half_h (r_height[DIM_W-1:1]),
        .o_valid  (sq_valid[0]),
        .i_ready  (sq_ready[0]),
        .o_item   (sq_item[0])
    );

    // Square root, one result bit per stage.
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        cfam_sqrt_step #(.STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[s]),
            .o_ready (sq_ready[s]),
            .i_item  (sq_item[s]),
            .o_valid (sq_valid[s+1]),
            .i_ready (sq_ready[s+1]),
            .o_item  (sq_item[s+1])
        );
    end

    // Zone decision and output register.
    cfam_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sq_valid[SQRT_STEPS]),
        .o_ready  (sq_ready[SQRT_STEPS]),
        .i_item   (sq_item[SQRT_STEPS]),
        .i_radius (r_radius),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pix    (out_pix)
    );

    assign o_red_out   = out_pix.red;
    assign o_green_out = out_pix.green;
    assign o_blue_out  = out_pix.blue;
    assign o_alpha_out = out_pix.alpha;

`ifndef NO_ASSERTIONS
    // Input back-pressure only arises from a full pipeline behind a stalled output.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a stalled output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");
`endif

endmodule
